### design/refcounted_handle_pool_assert.svh
// Assertion macros shared by the checker of the handle pool.
// Depends on nothing; included by the checker file.
`ifndef REFCOUNTED_HANDLE_POOL_ASSERT_SVH
`define REFCOUNTED_HANDLE_POOL_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RHP_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("rhp check failed");
// Next-cycle implication checked outside reset.
`define RHP_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("rhp check failed");
`endif

### design/rhp_pkg.sv
// Package of the handle pool: sizes, operation and status codes, queue entry type.
// Depends on nothing.
`default_nettype none
package rhp_pkg;
    localparam int ARENAS = 4;
    localparam int ARENA_SLOTS = 256;
    localparam int TOTAL_SLOTS = ARENAS * ARENA_SLOTS;
    localparam int AW = $clog2(ARENAS);
    localparam int SW = $clog2(ARENA_SLOTS);
    localparam int IW = $clog2(TOTAL_SLOTS);
    localparam int UW = $clog2(ARENA_SLOTS + 1);

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_GET = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_DESTROY = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_BUSY = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_ZERO = 3'd5;
    localparam logic [2:0] ST_OVF = 3'd6;

    localparam int RIDX_TAG = 0;
    localparam int RIDX_AUTO = 1;
    localparam int RIDX_ARENAS = 2;

    // Classified operation handed from front to back.
    typedef struct packed {
        logic [2:0]  op;
        logic        bad;      // handle check or op code failed
        logic [31:0] handle;
        logic [31:0] payload;
        logic [AW-1:0] arena;
        logic [SW-1:0] slot;
    } t_cmd;
endpackage
`default_nettype wire

### design/rhp_front.sv
// Front end of the handle pool: accepts operations, checks handles, queues commands.
// Depends on rhp_pkg.
`default_nettype none
module rhp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [2:0]    i_op,
    input  wire logic [31:0]   i_handle,
    input  wire logic [31:0]   i_payload,
    input  wire logic [7:0]    i_pool_tag,
    input  wire logic [2:0]    i_live,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_take,
    output rhp_pkg::t_cmd      o_cmd
);
    import rhp_pkg::*;
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd w_c;
    logic [7:0] w_tag, w_ar;
    logic [15:0] w_sl;
    logic w_push;

    always_comb begin
        w_tag = i_handle[31:24];
        w_ar = i_handle[23:16];
        w_sl = i_handle[15:0];
        w_c.op = i_op;
        w_c.handle = i_handle;
        w_c.payload = i_payload;
        w_c.arena = w_ar[AW-1:0];
        w_c.slot = w_sl[SW-1:0];
        w_c.bad = 1'b0;
        if (i_op > OP_QUERY) begin
            w_c.bad = 1'b1;
        end else if (i_op != OP_CREATE) begin
            w_c.bad = (i_op != OP_QUERY && w_tag != i_pool_tag) ||
                      ({5'd0, w_ar} >= {10'd0, i_live}) ||
                      ({16'd0, w_sl} >= 32'(ARENA_SLOTS));
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_c;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_take);
        end
    end
endmodule
`default_nettype wire

### design/rhp_back.sv
// Back end of the handle pool: slot memory, clearing pass, free-slot scan, results.
// Depends on rhp_pkg.
`default_nettype none
module rhp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_take,
    input  wire rhp_pkg::t_cmd i_cmd,
    input  wire logic          i_auto,
    input  wire logic [2:0]    i_live,
    input  wire logic [7:0]    i_pool_tag,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [2:0]         o_status,
    output logic [31:0]        o_handle,
    output logic [31:0]        o_payload,
    output logic [15:0]        o_refs,
    output logic [10:0]        o_used
);
    import rhp_pkg::*;
    // Internal op code that marks a slot probe of a create scan.
    localparam logic [2:0] OP_PROBE = 3'd7;
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SCAN, S_OUT} t_state;
    t_state r_state;
    logic [31:0] m_pay [TOTAL_SLOTS];
    logic [15:0] m_ref [TOTAL_SLOTS];
    logic [31:0] r_rp;
    logic [15:0] r_rr;
    logic [IW-1:0] r_addr;
    logic [UW-1:0] r_used [ARENAS];
    logic [AW-1:0] r_last, r_ca;
    logic [AW:0] r_k;
    logic [SW:0] r_s;
    t_cmd r_cmd;
    logic r_we;
    logic [31:0] r_wp;
    logic [15:0] r_wr;
    logic [IW-1:0] r_wa;
    logic [2:0] w_n;
    logic [10:0] w_sum;

    assign w_n = (i_live > 3'(ARENAS)) ? 3'(ARENAS) : i_live;
    always_comb begin
        w_sum = 11'd0;
        for (int i = 0; i < ARENAS; i++) w_sum = w_sum + 11'(r_used[i]);
    end
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            m_pay[r_wa] <= r_wp;
            m_ref[r_wa] <= r_wr;
        end
        r_rp <= m_pay[r_addr];
        r_rr <= m_ref[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr <= '0;
            r_we <= 1'b1;
            r_wa <= '0;
            r_wp <= '0;
            r_wr <= '0;
            r_last <= '0;
            for (int i = 0; i < ARENAS; i++) r_used[i] <= '0;
        end else begin
            r_we <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_we <= 1'b1;
                    if (r_wa == IW'(TOTAL_SLOTS - 1)) begin
                        r_we <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_wa <= r_wa + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        o_status <= ST_OK;
                        o_payload <= '0;
                        o_refs <= '0;
                        if (i_cmd.bad) begin
                            o_status <= ST_BAD;
                            o_handle <= i_cmd.handle;
                            r_state <= S_OUT;
                        end else if (i_cmd.op == OP_CREATE) begin
                            o_handle <= '0;
                            if (i_cmd.payload == 0 || w_n == 0) begin
                                o_status <= (i_cmd.payload == 0) ? ST_ZERO : ST_FULL;
                                r_state <= S_OUT;
                            end else begin
                                r_ca <= ({1'b0, r_last} < w_n) ? r_last : '0;
                                r_k <= '0;
                                r_s <= '0;
                                r_state <= S_SCAN;
                            end
                        end else begin
                            o_handle <= i_cmd.handle;
                            r_addr <= {i_cmd.arena, i_cmd.slot};
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    r_state <= S_OUT;
                    r_wa <= r_addr;
                    r_wp <= r_rp;
                    o_refs <= r_rr;
                    if (r_cmd.op == OP_DESTROY) begin
                        if (r_rr != 0) o_status <= ST_BUSY;
                        else if (r_rp == 0) o_status <= ST_NOTFOUND;
                        else begin
                            r_we <= 1'b1;
                            r_wp <= '0;
                            r_wr <= r_rr;
                            if (r_used[r_cmd.arena] != 0)
                                r_used[r_cmd.arena] <= r_used[r_cmd.arena] - 1'b1;
                        end
                    end else if (r_rp == 0 || r_rr == 0) begin
                        o_status <= ST_NOTFOUND;
                    end else if (r_cmd.op == OP_GET) begin
                        if (r_rr == 16'hFFFF) o_status <= ST_OVF;
                        else begin
                            r_we <= 1'b1;
                            r_wr <= r_rr + 1'b1;
                            o_refs <= r_rr + 1'b1;
                            o_payload <= r_rp;
                        end
                    end else if (r_cmd.op == OP_RELEASE) begin
                        r_we <= 1'b1;
                        r_wr <= r_rr - 1'b1;
                        o_refs <= r_rr - 1'b1;
                        if (i_auto && r_rr == 16'd1) begin
                            r_wp <= '0;
                            if (r_used[r_cmd.arena] != 0)
                                r_used[r_cmd.arena] <= r_used[r_cmd.arena] - 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    // Each probe sets the address, reads the memory, then checks the slot.
                    if (r_k == w_n) begin
                        o_status <= ST_FULL;
                        r_state <= S_OUT;
                    end else if (r_used[r_ca] >= UW'(ARENA_SLOTS)) begin
                        r_k <= r_k + 1'b1;
                        r_ca <= ({1'b0, r_ca} + 1'b1 >= w_n) ? '0 : r_ca + 1'b1;
                    end else begin
                        r_addr <= {r_ca, r_s[SW-1:0]};
                        r_state <= S_READ;
                        r_cmd.op <= OP_PROBE;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_EXEC && r_cmd.op == OP_PROBE) begin
                // Probe result of a create scan.
                r_state <= S_SCAN;
                if (r_rp == 0 && r_rr == 0) begin
                    r_we <= 1'b1;
                    r_wa <= r_addr;
                    r_wp <= r_cmd.payload;
                    r_wr <= 16'd1;
                    r_used[r_ca] <= r_used[r_ca] + 1'b1;
                    r_last <= r_ca;
                    o_status <= ST_OK;
                    o_refs <= 16'd1;
                    o_handle <= {i_pool_tag, 8'(r_ca), 16'(r_s[SW-1:0])};
                    r_state <= S_OUT;
                end else if (r_s == (SW+1)'(ARENA_SLOTS - 1)) begin
                    r_s <= '0;
                    r_k <= r_k + 1'b1;
                    r_ca <= ({1'b0, r_ca} + 1'b1 >= w_n) ? '0 : r_ca + 1'b1;
                end else begin
                    r_s <= r_s + 1'b1;
                end
            end
        end
    end

    assign o_used = w_sum;
endmodule
`default_nettype wire

### design/refcounted_handle_pool.sv
// Top level of the reference-counted handle pool.
// Depends on rhp_pkg, rhp_front and rhp_back.
//
// Channel   Dir  Contents
// s_axis    in   tdata: op[2:0], handle[34:3], payload[66:35]
// m_axis    out  tdata: status[2:0], handle_out[34:3], payload_out[66:35],
//                ref_count[82:67], used_total[93:83]
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// After reset a clearing pass empties the slot memory; commands queue in the front
// end meanwhile. Get, release, destroy and query pass through the back end states
// take, read, execute and result; a rejected command goes from take to result.
// Create probes one slot at a time, starting in the arena of the last create, skips
// each full arena and stays in the first arena that is not full.
// A stalled result holds the back end; the two-entry command queue keeps accepting until it fills.
`default_nettype none
module refcounted_handle_pool (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,   // op, handle, payload
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,   // status, handle_out, payload_out, ref_count, used_total
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [7:0]   i_cfg_data
);
    import rhp_pkg::*;
    logic [7:0] r_tag;
    logic r_auto;
    logic [2:0] r_arenas;
    logic w_cv, w_take;
    t_cmd w_cmd;
    logic [2:0] w_st;
    logic [31:0] w_h, w_p;
    logic [15:0] w_r;
    logic [10:0] w_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= 8'd1;
            r_auto <= 1'b1;
            r_arenas <= 3'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                2'(RIDX_TAG): r_tag <= i_cfg_data;
                2'(RIDX_AUTO): r_auto <= i_cfg_data[0];
                2'(RIDX_ARENAS): r_arenas <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    rhp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[2:0]), .i_handle(s_axis_tdata[34:3]),
        .i_payload(s_axis_tdata[66:35]),
        .i_pool_tag(r_tag), .i_live(r_arenas > 3'(ARENAS) ? 3'(ARENAS) : r_arenas),
        .o_cmd_valid(w_cv), .i_cmd_take(w_take), .o_cmd(w_cmd)
    );

    rhp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cv), .o_cmd_take(w_take), .i_cmd(w_cmd),
        .i_auto(r_auto), .i_live(r_arenas), .i_pool_tag(r_tag),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_st), .o_handle(w_h), .o_payload(w_p), .o_refs(w_r), .o_used(w_u)
    );

    assign m_axis_tdata = {2'd0, w_u, w_r, w_p, w_h, w_st};
endmodule
`default_nettype wire

### design/rhp_checker.sv
// Port-level checker for the handle pool, bound to the top level.
// Depends on rhp_pkg and refcounted_handle_pool_assert.svh.
`default_nettype none
`include "refcounted_handle_pool_assert.svh"
module rhp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata
);
    import rhp_pkg::*;
    `RHP_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `RHP_ASSERT_IMP(a_status, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= ST_OVF)
    `RHP_ASSERT_IMP(a_used, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[93:83] <= 11'(TOTAL_SLOTS))
    `RHP_ASSERT_IMP(a_okcnt, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2:0] == ST_OVF, m_axis_tdata[82:67] == 16'hFFFF)
endmodule
bind refcounted_handle_pool rhp_checker u_chk (.*);
`default_nettype wire

### tb/refcounted_handle_pool_tb.sv
// Self-checking testbench of the reference-counted handle pool.
// Depends on rhp_pkg and the refcounted_handle_pool RTL; drives directed and random stream
// traffic and checks every result transfer against a pool model or a typed table row.
`timescale 1ns / 100ps
`default_nettype none
module refcounted_handle_pool_tb;
    import rhp_pkg::*;

    // Op codes that the block does not define; they must come back as a bad handle.
    localparam logic [2:0] OP_UNDEF5 = 3'd5;
    localparam logic [2:0] OP_UNDEF6 = 3'd6;
    localparam logic [2:0] OP_UNDEF7 = 3'd7;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] handle;
        logic [31:0] payload;
        logic [15:0] refs;
        logic [10:0] used;
    } op_result_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] handle;
        logic [31:0] payload;
        bit          typed;     // expectation written in the table, not predicted
        op_result_t  res;
    } table_row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [7:0]   i_cfg_data;

    refcounted_handle_pool DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow copy of the pool: contents, counts, occupancy and configuration.
    logic [31:0] pool_payload [TOTAL_SLOTS];
    logic [15:0] pool_refs [TOTAL_SLOTS];
    int unsigned pool_used [ARENAS];
    int unsigned pool_last_arena;
    logic [7:0]  cur_tag;
    logic        cur_auto_free;
    logic [2:0]  cur_arenas;

    op_result_t  expected_results[$];
    table_row_t  directed_rows[$];
    int          mismatches = 0;
    int          transfers_out = 0;
    int          status_seen [8] = '{default: 0};
    int          ready_hold = 0;
    bit          idling_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The whole run, with slow creates and long stalls on both sides, fits well below this.
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned live_arenas();
        return (cur_arenas > ARENAS) ? ARENAS : cur_arenas;
    endfunction

    // Applies one operation to the shadow pool and returns the result it causes.
    function automatic op_result_t apply_op(logic [2:0] op, logic [31:0] h, logic [31:0] pl);
        op_result_t  res;
        int unsigned n, start, a, s, idx, k;
        bit          found;
        logic [7:0]  tag;
        logic [15:0] r;
        n = live_arenas();
        res = '0;
        res.status = ST_OK;
        res.handle = h;
        found = 1'b0;
        a = 0;
        s = 0;
        if (op == OP_CREATE) begin
            res.handle = '0;
            if (pl == 0) begin
                res.status = ST_ZERO;
            end else begin
                start = (pool_last_arena < n) ? pool_last_arena : 0;
                for (k = 0; k < n && !found; k++) begin
                    a = (start + k) % n;
                    if (pool_used[a] >= ARENA_SLOTS) continue;
                    for (s = 0; s < ARENA_SLOTS; s++) begin
                        idx = a * ARENA_SLOTS + s;
                        if (pool_payload[idx] == 0 && pool_refs[idx] == 0) begin
                            found = 1'b1;
                            break;
                        end
                    end
                end
                if (!found) begin
                    res.status = ST_FULL;
                end else begin
                    idx = a * ARENA_SLOTS + s;
                    pool_payload[idx] = pl;
                    pool_refs[idx] = 16'd1;
                    pool_used[a]++;
                    pool_last_arena = a;
                    res.handle = {cur_tag, a[7:0], s[15:0]};
                    res.refs = 16'd1;
                end
            end
        end else if (op <= OP_QUERY) begin
            tag = h[31:24];
            a = h[23:16];
            s = h[15:0];
            if ((op != OP_QUERY && tag != cur_tag) || a >= n || s >= ARENA_SLOTS) begin
                res.status = ST_BAD;
            end else begin
                idx = a * ARENA_SLOTS + s;
                r = pool_refs[idx];
                if (op == OP_DESTROY) begin
                    // Destroy only frees a slot whose count already went to zero.
                    if (r != 0) res.status = ST_BUSY;
                    else if (pool_payload[idx] == 0) res.status = ST_NOTFOUND;
                    else begin
                        pool_payload[idx] = '0;
                        if (pool_used[a] > 0) pool_used[a]--;
                    end
                end else if (pool_payload[idx] == 0 || r == 0) begin
                    res.status = ST_NOTFOUND;
                end else if (op == OP_GET) begin
                    if (r == 16'hFFFF) res.status = ST_OVF;
                    else begin
                        pool_refs[idx] = r + 16'd1;
                        res.payload = pool_payload[idx];
                    end
                end else if (op == OP_RELEASE) begin
                    pool_refs[idx] = r - 16'd1;
                    if (cur_auto_free && r == 16'd1) begin
                        pool_payload[idx] = '0;
                        if (pool_used[a] > 0) pool_used[a]--;
                    end
                end
                res.refs = pool_refs[idx];
            end
        end else begin
            res.status = ST_BAD;
        end
        res.used = pool_used[0] + pool_used[1] + pool_used[2] + pool_used[3];
        return res;
    endfunction

    // Offers one transfer on the input stream and predicts its result once it is taken.
    // A typed expectation replaces the predicted one, but the shadow pool still advances.
    task automatic send_op(logic [2:0] op, logic [31:0] h, logic [31:0] pl,
                           bit typed = 1'b0, op_result_t typed_res = '0);
        int         gap;
        op_result_t res;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, pl, h, op};
        do @(posedge i_clk); while (!s_axis_tready);
        res = apply_op(op, h, pl);
        expected_results.push_back(typed ? typed_res : res);
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[1:0];
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx == RIDX_TAG) cur_tag = value;
        else if (idx == RIDX_AUTO) cur_auto_free = value[0];
        else if (idx == RIDX_ARENAS) cur_arenas = value[2:0];
    endtask

    // Mostly handles that reach slots near the bottom of a usable arena, or of arena 0 to 3
    // if none is usable, and now and then a fully random word that exercises every handle bit.
    function automatic logic [31:0] pick_handle();
        int unsigned n;
        n = live_arenas();
        if ($urandom_range(0, 99) < 15) return $urandom;
        return {cur_tag, 8'($urandom_range(0, (n == 0) ? 3 : n - 1)),
                16'($urandom_range(0, 47))};
    endfunction

    task automatic random_ops(int count);
        int          r;
        logic [2:0]  op;
        logic [31:0] pl;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 32) op = OP_CREATE;
            else if (r < 54) op = OP_GET;
            else if (r < 76) op = OP_RELEASE;
            else if (r < 87) op = OP_DESTROY;
            else if (r < 96) op = OP_QUERY;
            else if (r < 97) op = OP_UNDEF5;
            else if (r < 98) op = OP_UNDEF6;
            else op = OP_UNDEF7;
            pl = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
            send_op(op, pick_handle(), pl);
        end
    endtask

    function automatic void add_row(logic [2:0] op, logic [31:0] h, logic [31:0] pl,
                                    bit typed = 1'b0, logic [2:0] st = ST_OK,
                                    logic [31:0] hout = '0, logic [31:0] pout = '0,
                                    logic [15:0] cnt = '0, logic [10:0] used = '0);
        table_row_t row;
        row.op = op;
        row.handle = h;
        row.payload = pl;
        row.typed = typed;
        row.res = '{status: st, handle: hout, payload: pout, refs: cnt, used: used};
        directed_rows.push_back(row);
    endfunction

    // Result side: random stalls of short and long length, and each transfer
    // compared with the oldest expectation, field by field.
    always @(posedge i_clk) begin
        op_result_t got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{status: m_axis_tdata[2:0], handle: m_axis_tdata[34:3],
                        payload: m_axis_tdata[66:35], refs: m_axis_tdata[82:67],
                        used: m_axis_tdata[93:83]};
                transfers_out++;
                status_seen[got.status]++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold = ready_hold - 1;
                m_axis_tready <= 1'b0;
            end else begin
                ready_hold = gap_len();
                m_axis_tready <= (ready_hold == 0);
                if (ready_hold > 0) ready_hold = ready_hold - 1;
            end
        end
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        foreach (pool_payload[i]) begin
            pool_payload[i] = '0;
            pool_refs[i] = '0;
        end
        foreach (pool_used[i]) pool_used[i] = 0;
        pool_last_arena = 0;
        cur_tag = 8'd1;
        cur_auto_free = 1'b1;
        cur_arenas = 3'd2;

        // Directed part at the reset settings: tag 1, auto free on, two arenas.
        add_row(OP_CREATE, 32'h0, 32'h0, 1, ST_ZERO, 32'h0, 32'h0, 16'd0, 11'd0);
        add_row(OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK, 32'h0100_0000,
                32'h0, 16'd1, 11'd1);
        add_row(OP_CREATE, 32'h0, 32'h1, 1, ST_OK, 32'h0100_0001, 32'h0, 16'd1, 11'd2);
        add_row(OP_GET, 32'h0100_0000, 32'h0, 1, ST_OK, 32'h0100_0000, 32'hFFFF_FFFF,
                16'd2, 11'd2);
        add_row(OP_RELEASE, 32'h0100_0000, 32'h0, 1, ST_OK, 32'h0100_0000, 32'h0,
                16'd1, 11'd2);
        add_row(OP_DESTROY, 32'h0100_0000, 32'h0, 1, ST_BUSY, 32'h0100_0000, 32'h0,
                16'd1, 11'd2);
        add_row(OP_QUERY, 32'h0100_0001, 32'h0);
        // A count query ignores the tag; the other ops reject it.
        add_row(OP_QUERY, 32'hFF00_0001, 32'h0, 1, ST_OK, 32'hFF00_0001, 32'h0,
                16'd1, 11'd2);
        add_row(OP_GET, 32'hFF00_0001, 32'h0, 1, ST_BAD, 32'hFF00_0001, 32'h0,
                16'd0, 11'd2);
        // Arena equal to the usable count, slot one past the end, slot at its maximum.
        add_row(OP_GET, 32'h0102_0000, 32'h0, 1, ST_BAD, 32'h0102_0000, 32'h0,
                16'd0, 11'd2);
        add_row(OP_GET, 32'h0100_0100, 32'h0, 1, ST_BAD, 32'h0100_0100, 32'h0,
                16'd0, 11'd2);
        add_row(OP_RELEASE, 32'h0100_FFFF, 32'h0, 1, ST_BAD, 32'h0100_FFFF, 32'h0,
                16'd0, 11'd2);
        add_row(OP_GET, 32'h0101_0000, 32'h0, 1, ST_NOTFOUND, 32'h0101_0000, 32'h0,
                16'd0, 11'd2);
        add_row(OP_UNDEF5, 32'h0100_0000, 32'h5, 1, ST_BAD, 32'h0100_0000, 32'h0,
                16'd0, 11'd2);
        add_row(OP_UNDEF6, 32'h0100_0001, 32'h6, 1, ST_BAD, 32'h0100_0001, 32'h0,
                16'd0, 11'd2);
        add_row(OP_UNDEF7, 32'hFFFF_FFFF, 32'h7, 1, ST_BAD, 32'hFFFF_FFFF, 32'h0,
                16'd0, 11'd2);
        // The last release frees the slot; touching it again finds nothing.
        add_row(OP_RELEASE, 32'h0100_0001, 32'h0, 1, ST_OK, 32'h0100_0001, 32'h0,
                16'd0, 11'd1);
        add_row(OP_RELEASE, 32'h0100_0001, 32'h0, 1, ST_NOTFOUND, 32'h0100_0001,
                32'h0, 16'd0, 11'd1);
        add_row(OP_DESTROY, 32'h0100_0001, 32'h0, 1, ST_NOTFOUND, 32'h0100_0001,
                32'h0, 16'd0, 11'd1);
        add_row(OP_QUERY, 32'h0100_0005, 32'h0);
        add_row(OP_CREATE, 32'h0, 32'h8000_0000);
        add_row(OP_GET, 32'h0100_0001, 32'h0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].handle,
                    directed_rows[i].payload, directed_rows[i].typed, directed_rows[i].res);
        drain();

        // Manual freeing with the widest tag and every arena in use.
        write_reg(RIDX_AUTO, 8'd0);
        write_reg(RIDX_TAG, 8'hFF);
        write_reg(RIDX_ARENAS, 8'd4);
        random_ops(90);
        drain();

        // Arena count above the table size acts as the table size.
        write_reg(RIDX_AUTO, 8'd1);
        write_reg(RIDX_TAG, 8'h5A);
        write_reg(RIDX_ARENAS, 8'd7);
        random_ops(60);
        drain();

        // No usable arena: every create with a nonzero payload is full and every handle is rejected.
        write_reg(RIDX_ARENAS, 8'd0);
        random_ops(20);
        drain();

        // One arena filled to the top, then some churn around the full state.
        write_reg(RIDX_TAG, 8'd1);
        write_reg(RIDX_ARENAS, 8'd1);
        for (int i = 0; i < 260; i++) send_op(OP_CREATE, $urandom, $urandom | 32'd1);
        random_ops(40);
        drain();

        // Three arenas, so creates spill past the full one.
        write_reg(RIDX_ARENAS, 8'd3);
        random_ops(60);
        drain();

        $display("Result transfers checked: %0d, mismatches: %0d.", transfers_out, mismatches);
        $display("Status mix ok/bad/notfound/busy/full/zero/ovf: %0d/%0d/%0d/%0d/%0d/%0d/%0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
